FILE: rtl/ljpf_pkg.sv
`timescale 1ns / 1ps
package ljpf_pkg;

	localparam int PARTICLES = 1024;
	localparam int PTR_W     = $clog2(PARTICLES);

	typedef enum logic [1:0] {
		SH_0,
		SH_16,
		SH_32
	} shift_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL_GO,
		S_MUL_WAIT,
		S_DIV_GO,
		S_DIV_WAIT,
		S_RD_A,
		S_WR_A,
		S_RD_B,
		S_WR_B,
		S_GET,
		S_GET_CLR
	} state_t;

	typedef enum logic [3:0] {
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_I4,
		ST_I6,
		ST_A1,
		ST_T1,
		ST_T2,
		ST_H,
		ST_F_X,
		ST_F_Y,
		ST_F_Z
	} step_t;

	typedef struct packed {
		logic signed [47:0] x;
		logic signed [47:0] y;
		logic signed [47:0] z;
	} force_vec_t;

	typedef struct packed {
		logic [31:0] repel;
		logic [31:0] attract;
	} coef_pair_t;

endpackage

FILE: rtl/ljpf_mul.sv
`timescale 1ns / 1ps
module ljpf_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [63:0]       op_a,
	input  logic [63:0]       op_b,
	input  ljpf_pkg::shift_t  shift,
	output logic [63:0]       prod,
	output logic              sat,
	output logic              done
);
	import ljpf_pkg::*;

	logic [63:0]  a_q, b_q;
	shift_t       shift_q;
	logic [2:0]   cnt_q;
	logic         run_q;
	logic [63:0]  pp_s1;
	logic [1:0]   pos_s1;
	logic [127:0] acc_q;
	logic [31:0]  a_half, b_half;
	logic [127:0] pp_wide;
	logic [63:0]  res;
	logic         res_sat;

	assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (pos_s1)
			2'd0:    pp_wide = {64'd0, pp_s1};
			2'd1:    pp_wide = {32'd0, pp_s1, 32'd0};
			default: pp_wide = {pp_s1, 64'd0};
		endcase
	end

	always_comb begin
		case (shift_q)
			SH_0: begin
				res_sat = |acc_q[127:64];
				res     = acc_q[63:0];
			end
			SH_16: begin
				res_sat = |acc_q[127:80];
				res     = acc_q[79:16];
			end
			default: begin
				res_sat = |acc_q[127:96];
				res     = acc_q[95:32];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 3'd0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q     <= op_a;
			b_q     <= op_b;
			shift_q <= shift;
			acc_q   <= '0;
		end else if (run_q) begin
			if (cnt_q < 3'd4) begin
				pp_s1  <= a_half * b_half;
				pos_s1 <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + pp_wide;
			if (cnt_q == 3'd5) begin
				prod <= res_sat ? '1 : res;
				sat  <= res_sat;
			end
		end
	end

endmodule

FILE: rtl/ljpf_recip.sv
`timescale 1ns / 1ps
module ljpf_recip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [47:0] r,
	output logic [63:0] q,
	output logic        sat,
	output logic        done
);
	logic [47:0] r_q;
	logic [47:0] rem_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [48:0] rem2;
	logic        ge;
	logic [48:0] rem_sub;

	assign rem2    = {rem_q, 1'b0};
	assign ge      = rem2 >= {1'b0, r_q};
	assign rem_sub = rem2 - {1'b0, r_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= 6'd0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				cnt_q <= 6'd0;
				if (r == 48'd1)
					done <= 1'b1;
				else
					run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			r_q   <= r;
			rem_q <= 48'd1;
			q     <= (r == 48'd1) ? '1 : '0;
			sat   <= (r == 48'd1);
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[47:0] : rem2[47:0];
			q     <= {q[62:0], ge};
		end
	end

endmodule

FILE: rtl/ljpf_force_mem.sv
`timescale 1ns / 1ps
module ljpf_force_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ljpf_pkg::PTR_W-1:0]    waddr,
	input  ljpf_pkg::force_vec_t          wdata,
	input  logic [ljpf_pkg::PTR_W-1:0]    raddr,
	output ljpf_pkg::force_vec_t          rdata
);
	import ljpf_pkg::*;

	force_vec_t mem [PARTICLES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/lj_pair_force_accumulate_core.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     start / busy               kind, index_a/b, type_a/b, pos_a_*, pos_b_*
// result    done (one-cycle strobe)    force_x/y/z, saturated, too_close, pair_count
// config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Pair transaction: busy through the 64-step reciprocal divider, twelve passes through the
// four-partial-product 32x32 multiplier and the memory states S_RD_A, S_WR_A, S_RD_B, S_WR_B.
// Zero separation ends after the three squares.
// Read transaction: states S_GET and S_GET_CLR through the force memory read/write port.
// After reset a clearing pass zeroes all 1024 force memory entries with busy high.
// The result is shown for one cycle on done, in the first cycle with busy low; no stall.
module lj_pair_force_accumulate_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [9:0]         index_a,
	input  logic [9:0]         index_b,
	input  logic               type_a,
	input  logic               type_b,
	input  logic [22:0]        pos_a_x,
	input  logic [22:0]        pos_a_y,
	input  logic [22:0]        pos_a_z,
	input  logic [22:0]        pos_b_x,
	input  logic [22:0]        pos_b_y,
	input  logic [22:0]        pos_b_z,
	output logic               done,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic signed [47:0] force_z,
	output logic               saturated,
	output logic               too_close,
	output logic [39:0]        pair_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ljpf_pkg::*;

	localparam logic signed [49:0] ACC_HI = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] ACC_LO = 50'sh3_8000_0000_0000;
	localparam logic [63:0] MAG_POS = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] MAG_NEG = 64'h0000_8000_0000_0000;

	function automatic logic [48:0] clip_add(logic signed [47:0] x, logic signed [47:0] y,
			logic sub);
		logic signed [49:0] s;
		s = sub ? ({{2{x[47]}}, x} - {{2{y[47]}}, y}) : ({{2{x[47]}}, x} + {{2{y[47]}}, y});
		if (s > ACC_HI)
			return {1'b1, ACC_HI[47:0]};
		else if (s < ACC_LO)
			return {1'b1, ACC_LO[47:0]};
		else
			return {1'b0, s[47:0]};
	endfunction

	state_t      state_q, state_d;
	logic [PTR_W-1:0] clr_addr_q;
	coef_pair_t  coef_q [4];
	logic        kind_q;
	logic [PTR_W-1:0] ia_q, ib_q;
	logic [1:0]  sel_q;
	logic [2:0][22:0] dm_q;
	logic [2:0]  dneg_q;
	step_t       step_q;
	logic [47:0] r2_q;
	logic [63:0] i2_q, tmp_q, i6_q, t1_q, t2_q, h_q;
	logic        gneg_q;
	logic signed [47:0] f_q [3];
	logic        sat_q;
	logic [39:0] count_q;

	logic        accept;
	logic [2:0][22:0] dm_in;
	logic [2:0]  dneg_in;
	logic signed [23:0] diff [3];

	logic        mul_go, mul_sat, mul_done;
	logic [63:0] mul_a, mul_b, mul_prod;
	shift_t      mul_shift;
	logic        div_go, div_sat, div_done;
	logic [63:0] div_q;

	logic        mem_we;
	logic [PTR_W-1:0] mem_waddr, mem_raddr;
	force_vec_t  mem_wdata, mem_rdata;

	logic [1:0]  axis;
	logic [3:0]  axis_off;
	logic [63:0] gmag;
	logic [47:0] r2_next;
	logic        fneg, fover;
	logic [47:0] fmag;
	logic signed [47:0] fval;
	logic [48:0] add_x, add_y, add_z;
	logic        add_sat, add_sub;
	logic        finish, close_fin;
	coef_pair_t  coef_sel;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign coef_sel  = coef_q[sel_q];

	always_comb begin
		diff[0] = {1'b0, pos_a_x} - {1'b0, pos_b_x};
		diff[1] = {1'b0, pos_a_y} - {1'b0, pos_b_y};
		diff[2] = {1'b0, pos_a_z} - {1'b0, pos_b_z};
		for (int k = 0; k < 3; k++) begin
			dneg_in[k] = diff[k][23];
			dm_in[k]   = diff[k][23] ? 23'(-diff[k]) : diff[k][22:0];
		end
	end

	assign axis_off = step_q - ST_F_X;
	assign axis     = (step_q >= ST_F_X) ? axis_off[1:0] : step_q[1:0];
	assign gmag     = gneg_q ? (t2_q - t1_q) : (t1_q - t2_q);
	assign r2_next  = r2_q + mul_prod[47:0];

	always_comb begin
		mul_shift = SH_32;
		mul_a     = {41'd0, dm_q[axis]};
		mul_b     = h_q;
		case (step_q)
			ST_SQ_X, ST_SQ_Y, ST_SQ_Z: begin
				mul_shift = SH_0;
				mul_b     = {41'd0, dm_q[axis]};
			end
			ST_I4: begin
				mul_a = i2_q;
				mul_b = i2_q;
			end
			ST_I6: begin
				mul_a = tmp_q;
				mul_b = i2_q;
			end
			ST_A1: begin
				mul_shift = SH_16;
				mul_a     = {32'd0, coef_sel.repel};
				mul_b     = i6_q;
			end
			ST_T1: begin
				mul_a = tmp_q;
				mul_b = i6_q;
			end
			ST_T2: begin
				mul_shift = SH_16;
				mul_a     = {32'd0, coef_sel.attract};
				mul_b     = i6_q;
			end
			ST_H: begin
				mul_a = gmag;
				mul_b = i2_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		fneg  = gneg_q ^ dneg_q[axis];
		fover = fneg ? (mul_prod > MAG_NEG) : (mul_prod > MAG_POS);
		fmag  = fover ? (fneg ? MAG_NEG[47:0] : MAG_POS[47:0]) : mul_prod[47:0];
		fval  = fneg ? -$signed(fmag) : $signed(fmag);
	end

	assign add_sub = (state_q == S_WR_B);
	assign add_x   = clip_add(mem_rdata.x, f_q[0], add_sub);
	assign add_y   = clip_add(mem_rdata.y, f_q[1], add_sub);
	assign add_z   = clip_add(mem_rdata.z, f_q[2], add_sub);
	assign add_sat = add_x[48] | add_y[48] | add_z[48];

	always_comb begin
		state_d   = state_q;
		mul_go    = 1'b0;
		div_go    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ia_q;
		mem_raddr = ia_q;
		mem_wdata = '0;
		finish    = 1'b0;
		close_fin = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				if (clr_addr_q == PTR_W'(PARTICLES - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start)
					state_d = kind ? S_GET : S_MUL_GO;
			end
			S_MUL_GO: begin
				mul_go  = 1'b1;
				state_d = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (mul_done) begin
					if (step_q == ST_SQ_Z) begin
						if (r2_next == 48'd0) begin
							finish    = 1'b1;
							close_fin = 1'b1;
							state_d   = S_IDLE;
						end else begin
							state_d = S_DIV_GO;
						end
					end else if (step_q == ST_F_Z) begin
						state_d = S_RD_A;
					end else begin
						state_d = S_MUL_GO;
					end
				end
			end
			S_DIV_GO: begin
				div_go  = 1'b1;
				state_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_done)
					state_d = S_MUL_GO;
			end
			S_RD_A: begin
				state_d = S_WR_A;
			end
			S_WR_A: begin
				mem_we    = 1'b1;
				mem_wdata = {add_x[47:0], add_y[47:0], add_z[47:0]};
				state_d   = S_RD_B;
			end
			S_RD_B: begin
				mem_raddr = ib_q;
				state_d   = S_WR_B;
			end
			S_WR_B: begin
				mem_we    = 1'b1;
				mem_waddr = ib_q;
				mem_wdata = {add_x[47:0], add_y[47:0], add_z[47:0]};
				finish    = 1'b1;
				state_d   = S_IDLE;
			end
			S_GET: begin
				state_d = S_GET_CLR;
			end
			S_GET_CLR: begin
				mem_we  = 1'b1;
				finish  = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			count_q    <= '0;
			done       <= 1'b0;
			coef_q[0]  <= '{repel: 32'd3145728, attract: 32'd1572864};
			coef_q[1]  <= '{repel: 32'd4718592, attract: 32'd2359296};
			coef_q[2]  <= '{repel: 32'd4718592, attract: 32'd2359296};
			coef_q[3]  <= '{repel: 32'd6291456, attract: 32'd3145728};
		end else begin
			state_q <= state_d;
			done    <= finish;
			if (state_q == S_CLEAR)
				clr_addr_q <= clr_addr_q + 1'b1;
			if (state_q == S_WR_B)
				count_q <= count_q + 40'd1;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index[0])
					coef_q[cfg_index[2:1]].attract <= cfg_data;
				else
					coef_q[cfg_index[2:1]].repel <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			ia_q   <= index_a;
			ib_q   <= index_b;
			sel_q  <= {type_a, type_b};
			dm_q   <= dm_in;
			dneg_q <= dneg_in;
			step_q <= ST_SQ_X;
			r2_q   <= '0;
			sat_q  <= 1'b0;
		end
		if (state_q == S_MUL_WAIT && mul_done) begin
			sat_q  <= sat_q | mul_sat | ((step_q >= ST_F_X) && fover);
			step_q <= step_t'(step_q + 4'd1);
			case (step_q)
				ST_SQ_X, ST_SQ_Y, ST_SQ_Z: r2_q <= r2_next;
				ST_I4, ST_A1: tmp_q <= mul_prod;
				ST_I6: i6_q <= mul_prod;
				ST_T1: t1_q <= mul_prod;
				ST_T2: begin
					t2_q   <= mul_prod;
					gneg_q <= t1_q < mul_prod;
				end
				ST_H: h_q <= mul_prod;
				default: f_q[axis] <= fval;
			endcase
		end
		if (state_q == S_DIV_WAIT && div_done) begin
			i2_q  <= div_q;
			sat_q <= sat_q | div_sat;
		end
		if (state_q == S_WR_A)
			sat_q <= sat_q | add_sat;
		if (finish) begin
			too_close <= close_fin;
			if (kind_q) begin
				force_x    <= mem_rdata.x;
				force_y    <= mem_rdata.y;
				force_z    <= mem_rdata.z;
				saturated  <= 1'b0;
				pair_count <= count_q;
			end else if (close_fin) begin
				force_x    <= '0;
				force_y    <= '0;
				force_z    <= '0;
				saturated  <= 1'b0;
				pair_count <= count_q;
			end else begin
				force_x    <= f_q[0];
				force_y    <= f_q[1];
				force_z    <= f_q[2];
				saturated  <= sat_q | add_sat;
				pair_count <= count_q + 40'd1;
			end
		end
	end

	ljpf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.shift  (mul_shift),
		.prod   (mul_prod),
		.sat    (mul_sat),
		.done   (mul_done)
	);

	ljpf_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.r      (r2_q),
		.q      (div_q),
		.sat    (div_sat),
		.done   (div_done)
	);

	ljpf_force_mem u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy || (state_q == S_GET) || (state_q == S_MUL_GO))
		else $error("result strobe while busy with older work");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && too_close) |-> (force_x == 48'sd0 && !saturated))
		else $error("too_close result carries force");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!mul_done && !div_done && !finish))
		else $error("activity during clearing pass");
`endif

endmodule

FILE: verif/tb_lj_pair_force_accumulate_core.sv
`timescale 1ns / 1ps
module tb_lj_pair_force_accumulate_core;
	import ljpf_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;

	typedef enum logic [2:0] {
		CR_REPEL_00,
		CR_ATTRACT_00,
		CR_REPEL_01,
		CR_ATTRACT_01,
		CR_REPEL_10,
		CR_ATTRACT_10,
		CR_REPEL_11,
		CR_ATTRACT_11
	} coef_reg_t;

	localparam logic KIND_PAIR = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct {
		logic        kind;
		logic [9:0]  ia;
		logic [9:0]  ib;
		logic        ta;
		logic        tb;
		logic [22:0] pa [3];
		logic [22:0] pb [3];
	} lj_item_t;

	typedef struct {
		logic [47:0] f [3];
		logic        sat;
		logic        close;
		logic [39:0] cnt;
	} lj_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic kind = 0;
	logic [9:0] index_a = 0, index_b = 0;
	logic type_a = 0, type_b = 0;
	logic [22:0] pos_a_x = 0, pos_a_y = 0, pos_a_z = 0;
	logic [22:0] pos_b_x = 0, pos_b_y = 0, pos_b_z = 0;
	logic done;
	logic signed [47:0] force_x, force_y, force_z;
	logic saturated, too_close;
	logic [39:0] pair_count;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	lj_pair_force_accumulate_core dut (.*);

	always #2 clk = ~clk;

	lj_item_t   pending_items [$];
	lj_item_t   cur_item;
	lj_result_t expected_forces [$];

	logic [31:0] coef_mirror [8];
	longint      acc_x [PARTICLES];
	longint      acc_y [PARTICLES];
	longint      acc_z [PARTICLES];
	logic [39:0] pair_total;
	int          errors = 0;
	int          cycles = 0;
	bit          taken = 0;
	int          burst_left = 0;
	int          gap_left = 0;

	task automatic enqueue_item(input lj_item_t it);
		pending_items = {pending_items, it};
	endtask

	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
			input int s, inout bit sat);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		if ((p >> (64 + s)) != 0) begin
			sat = 1;
			return '1;
		end
		p = p >> s;
		return p[63:0];
	endfunction

	function automatic longint clip_add(input longint a, input longint b, inout bit sat);
		longint s;
		longint fmax;
		fmax = 64'sd140737488355327;
		s = a + b;
		if (s > fmax) begin
			sat = 1;
			return fmax;
		end
		if (s < -fmax - 1) begin
			sat = 1;
			return -fmax - 1;
		end
		return s;
	endfunction

	function automatic lj_result_t predict_force(input lj_item_t it);
		lj_result_t r;
		longint f [3];
		longint d [3];
		logic [63:0] dm [3];
		logic [63:0] r2, i2, i6, t1, t2, h, m, lim;
		logic [127:0] q;
		bit sat, gneg, neg;
		int sel;
		sat = 0;
		r.close = 0;
		f = '{0, 0, 0};
		if (it.kind == KIND_READ) begin
			f[0] = acc_x[it.ia];
			f[1] = acc_y[it.ia];
			f[2] = acc_z[it.ia];
			acc_x[it.ia] = 0;
			acc_y[it.ia] = 0;
			acc_z[it.ia] = 0;
		end else begin
			sel = {it.ta, it.tb};
			r2 = 0;
			for (int k = 0; k < 3; k++) begin
				d[k] = longint'(it.pa[k]) - longint'(it.pb[k]);
				dm[k] = d[k] < 0 ? -d[k] : d[k];
				r2 += dm[k] * dm[k];
			end
			if (r2 == 0) begin
				r.close = 1;
			end else begin
				q = (128'd1 << 64) / {64'd0, r2};
				if ((q >> 64) != 0) begin
					sat = 1;
					i2 = '1;
				end else
					i2 = q[63:0];
				i6 = mul_shift(mul_shift(i2, i2, 32, sat), i2, 32, sat);
				t1 = mul_shift(mul_shift({32'd0, coef_mirror[2*sel]}, i6, 16, sat), i6, 32, sat);
				t2 = mul_shift({32'd0, coef_mirror[2*sel+1]}, i6, 16, sat);
				gneg = t1 < t2;
				h = mul_shift(gneg ? t2 - t1 : t1 - t2, i2, 32, sat);
				for (int k = 0; k < 3; k++) begin
					neg = gneg != (d[k] < 0);
					m = mul_shift(dm[k], h, 32, sat);
					lim = neg ? 64'd140737488355328 : 64'd140737488355327;
					if (m > lim) begin
						m = lim;
						sat = 1;
					end
					f[k] = neg ? -longint'(m) : longint'(m);
				end
				acc_x[it.ia] = clip_add(acc_x[it.ia], f[0], sat);
				acc_y[it.ia] = clip_add(acc_y[it.ia], f[1], sat);
				acc_z[it.ia] = clip_add(acc_z[it.ia], f[2], sat);
				acc_x[it.ib] = clip_add(acc_x[it.ib], -f[0], sat);
				acc_y[it.ib] = clip_add(acc_y[it.ib], -f[1], sat);
				acc_z[it.ib] = clip_add(acc_z[it.ib], -f[2], sat);
				pair_total = pair_total + 1;
			end
		end
		for (int k = 0; k < 3; k++)
			r.f[k] = f[k][47:0];
		r.sat = sat;
		r.cnt = pair_total;
		return r;
	endfunction

	always @(posedge clk) begin
		lj_result_t e;
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
		if (done) begin
			if (expected_forces.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result at cycle %0d", cycles);
			end else begin
				e = expected_forces.pop_front();
				if (e.f[0] !== force_x || e.f[1] !== force_y || e.f[2] !== force_z ||
						e.sat !== saturated || e.close !== too_close ||
						e.cnt !== pair_count) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp f=%h %h %h s=%b c=%b n=%h, got f=%h %h %h s=%b c=%b n=%h",
							e.f[0], e.f[1], e.f[2], e.sat, e.close, e.cnt,
							force_x, force_y, force_z, saturated, too_close, pair_count);
				end
			end
		end
		if (start && !busy && arst_n) begin
			e = predict_force(cur_item);
			expected_forces = {expected_forces, e};
			taken <= 1;
		end
	end

	always @(negedge clk) begin
		if (start && !taken) begin
			// hold until the transaction is accepted
		end else begin
			taken <= 0;
			if (gap_left > 0) begin
				gap_left--;
				start <= 0;
			end else if (pending_items.size() != 0) begin
				cur_item = pending_items.pop_front();
				kind <= cur_item.kind;
				index_a <= cur_item.ia;
				index_b <= cur_item.ib;
				type_a <= cur_item.ta;
				type_b <= cur_item.tb;
				pos_a_x <= cur_item.pa[0];
				pos_a_y <= cur_item.pa[1];
				pos_a_z <= cur_item.pa[2];
				pos_b_x <= cur_item.pb[0];
				pos_b_y <= cur_item.pb[1];
				pos_b_z <= cur_item.pb[2];
				start <= 1;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(0, 8);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
				end
			end else
				start <= 0;
		end
	end

	task automatic write_coef(input coef_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		coef_mirror[idx] = val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_coefs(input int mode);
		logic [31:0] v;
		for (int i = 0; i < 8; i++) begin
			case (mode)
				0: v = 32'hFFFF_FFFF;
				1: v = 32'd0;
				2: v = $urandom_range(0, 32'h00FF_FFFF);
				default: v = $urandom;
			endcase
			write_coef(coef_reg_t'(i), v);
		end
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() != 0 || start || busy || expected_forces.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic lj_item_t make_item(input int mode);
		lj_item_t it;
		int span;
		it.kind = KIND_PAIR;
		it.ia = 10'($urandom_range(0, 15));
		it.ib = 10'($urandom_range(0, 15));
		if ($urandom_range(0, 9) == 0) it.ia = 10'($urandom);
		if ($urandom_range(0, 9) == 0) it.ib = 10'($urandom);
		it.ta = 1'($urandom);
		it.tb = 1'($urandom);
		span = 1 << $urandom_range(4, 19);
		for (int k = 0; k < 3; k++) begin
			it.pa[k] = 23'($urandom);
			case (mode)
				0: it.pb[k] = 23'($urandom);
				1: it.pb[k] = it.pa[k];
				default: it.pb[k] = it.pa[k] + 23'($urandom_range(0, 2 * span)) - 23'(span);
			endcase
		end
		if (mode == 3) it.kind = KIND_READ;
		return it;
	endfunction

	task automatic queue_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			enqueue_item(make_item(r < 30 ? 3 : r < 37 ? 0 : r < 40 ? 1 : 2));
		end
	endtask

	task automatic queue_directed();
		lj_item_t it;
		it = make_item(2);
		it.ia = 0; it.ib = 1023; it.ta = 0; it.tb = 0;
		it.pa = '{23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF};
		it.pb = '{23'd0, 23'd0, 23'd0};
		enqueue_item(it);
		it.pa = '{23'd0, 23'd0, 23'd0};
		it.pb = '{23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF};
		enqueue_item(it);
		it.pb = '{23'd1, 23'd0, 23'd0};
		it.ta = 1;
		enqueue_item(it);
		it.pa = '{23'd100, 23'd200, 23'd300};
		it.pb = it.pa;
		enqueue_item(it);
		for (int t = 0; t < 4; t++) begin
			it = make_item(2);
			it.ia = 5; it.ib = 6; it.ta = t[1]; it.tb = t[0];
			it.pb = '{it.pa[0] + 23'h10000, it.pa[1], it.pa[2]};
			enqueue_item(it);
		end
		it = make_item(2);
		it.ia = 7; it.ib = 7;
		enqueue_item(it);
		for (int i = 0; i < 4; i++) begin
			it = make_item(2);
			it.ia = 9; it.ib = 10;
			enqueue_item(it);
		end
		it = make_item(3);
		foreach (it.pa[k]) it.pa[k] = 23'h7FFFFF;
		it.ia = 9; enqueue_item(it);
		it.ia = 10; enqueue_item(it);
		it.ia = 7; enqueue_item(it);
		it.ia = 1023; enqueue_item(it);
		it.ia = 0; enqueue_item(it);
		it.ia = 0; enqueue_item(it);
	endtask

	initial begin
		coef_mirror = '{32'd3145728, 32'd1572864, 32'd4718592, 32'd2359296,
			32'd4718592, 32'd2359296, 32'd6291456, 32'd3145728};
		for (int i = 0; i < PARTICLES; i++) begin
			acc_x[i] = 0;
			acc_y[i] = 0;
			acc_z[i] = 0;
		end
		pair_total = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		queue_directed();
		queue_random(250);
		wait_drained();
		set_coefs(2);
		queue_random(350);
		wait_drained();
		set_coefs(0);
		enqueue_item(make_item(3));
		queue_directed();
		queue_random(200);
		wait_drained();
		set_coefs(1);
		queue_random(200);
		wait_drained();
		set_coefs(3);
		queue_random(200);
		wait_drained();
		set_coefs(2);
		queue_random(400);
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
